// File: hdl/spec_language_lexer_unit_defines.svh
// Assertion macros for the lexer unit.
`ifndef SPEC_LANGUAGE_LEXER_UNIT_DEFINES_SVH
`define SPEC_LANGUAGE_LEXER_UNIT_DEFINES_SVH
// Assert that a property holds on every clock edge outside reset.
`define SLL_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Assert that a condition holds at every clock edge, reset included.
`define SLL_ASSERT_ALWAYS(lbl, clk, cond, msg) \
  lbl: assert property (@(posedge clk) (cond)) else $error(msg);
`endif

// File: hdl/sll_pkg.sv
// Package with the types, codes and classification functions of the lexer.
package sll_pkg;

  typedef enum logic [3:0] {
    MODE_IDLE, MODE_SLASH, MODE_LINE, MODE_BLOCK, MODE_BLOCK_STAR, MODE_IDENT,
    MODE_NUMBER, MODE_STRING, MODE_STRING_ESC, MODE_SYM, MODE_ERROR
  } mode_e;

  localparam logic [4:0] KIND_IDENT   = 5'd0;
  localparam logic [4:0] KIND_NUMBER  = 5'd1;
  localparam logic [4:0] KIND_STRING  = 5'd2;
  localparam logic [4:0] KIND_IFF     = 5'd3;
  localparam logic [4:0] KIND_IMPLIES = 5'd4;
  localparam logic [4:0] KIND_ANDAND  = 5'd5;
  localparam logic [4:0] KIND_OROR    = 5'd6;
  localparam logic [4:0] KIND_DOTDOT  = 5'd7;
  localparam logic [4:0] KIND_SINGLE0 = 5'd8;
  localparam logic [4:0] KIND_UNKNOWN = 5'd22;
  localparam logic [4:0] KIND_END     = 5'd23;

  localparam int unsigned MaxRes = 3;
  localparam int unsigned QueueDepth = 4;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [4:0] token_kind;
    logic [7:0] char_code_res;
    logic       has_char;
    logic       first_of_token;
    logic       last_of_token;
    logic       parse_error;
    logic       last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  count;
    out_item_t   res0;
    out_item_t   res1;
    out_item_t   res2;
  } batch_t;

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic [4:0] single_kind(input logic [7:0] c);
    logic [4:0] k;
    k = KIND_UNKNOWN;
    unique case (c)
      8'h7b: k = 5'd8;
      8'h7d: k = 5'd9;
      8'h28: k = 5'd10;
      8'h29: k = 5'd11;
      8'h5b: k = 5'd12;
      8'h5d: k = 5'd13;
      8'h3b: k = 5'd14;
      8'h3a: k = 5'd15;
      8'h2c: k = 5'd16;
      8'h40: k = 5'd17;
      8'h27: k = 5'd18;
      8'h21: k = 5'd19;
      8'h26: k = 5'd20;
      8'h7c: k = 5'd21;
      default: k = KIND_UNKNOWN;
    endcase
    return k;
  endfunction

  function automatic out_item_t mk(input logic [4:0] kind, input logic [7:0] ch,
                                   input logic has, input logic first,
                                   input logic last, input logic err);
    out_item_t r;
    r.token_kind = kind;
    r.char_code_res = has ? ch : 8'd0;
    r.has_char = has;
    r.first_of_token = first;
    r.last_of_token = last;
    r.parse_error = err;
    r.last_of_run = 1'b0;
    return r;
  endfunction

endpackage

// File: hdl/sll_front.sv
// Front end: classifies each item, advances lexer state and forms a batch of results.
module sll_front import sll_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     take_i,
  input  in_item_t item_i,
  output batch_t   batch_o
);

  mode_e      mode_q, mode_d;
  logic [7:0] h0_q, h0_d, h1_q, h1_d;
  logic [1:0] cnt_q, cnt_d;
  logic       started_q, started_d;
  batch_t     b;
  out_item_t  r [MaxRes];
  logic [1:0] n;
  logic [7:0] c;

  always_comb begin
    logic       st_done;
    mode_e      sm;
    logic [7:0] s0;
    logic [1:0] sc;
    logic       restart;
    logic       more;
    logic [4:0] kind;
    logic [4:0] mk_kind;
    c = item_i.char_code;
    mode_d = mode_q;
    h0_d = h0_q;
    h1_d = h1_q;
    cnt_d = cnt_q;
    started_d = started_q;
    n = 2'd0;
    for (int i = 0; i < MaxRes; i++) r[i] = '0;
    restart = 1'b0;
    st_done = 1'b0;
    sm = MODE_IDLE;
    s0 = 8'd0;
    sc = 2'd0;
    more = 1'b0;
    kind = KIND_IDENT;
    mk_kind = KIND_IDENT;
    if (mode_q == MODE_ERROR) begin
      n = 2'd0;
    end else if (item_i.end_of_input) begin
      unique case (mode_q)
        MODE_IDENT, MODE_NUMBER: begin
          r[0] = mk(mode_q == MODE_IDENT ? KIND_IDENT : KIND_NUMBER, h0_q, 1'b1,
                    !started_q, 1'b1, 1'b0);
          n = 2'd1;
        end
        MODE_SLASH: begin
          r[0] = mk(KIND_UNKNOWN, 8'h2f, 1'b1, 1'b1, 1'b1, 1'b0);
          n = 2'd1;
        end
        MODE_SYM: begin
          r[0] = mk(single_kind(h0_q), h0_q, 1'b1, 1'b1, 1'b1, 1'b0);
          r[1] = mk(single_kind(h1_q), h1_q, 1'b1, 1'b1, 1'b1, 1'b0);
          n = (cnt_q >= 2'd2) ? 2'd2 : 2'd1;
        end
        default: n = 2'd0;
      endcase
      if (mode_q == MODE_STRING || mode_q == MODE_STRING_ESC) begin
        r[0] = mk(KIND_STRING, 8'd0, 1'b0, 1'b0, 1'b0, 1'b1);
        n = 2'd1;
        mode_d = MODE_ERROR;
      end else begin
        r[n] = mk(KIND_END, 8'd0, 1'b0, 1'b1, 1'b1, 1'b0);
        n = n + 2'd1;
        mode_d = MODE_IDLE;
      end
      h0_d = 8'd0;
      h1_d = 8'd0;
      cnt_d = 2'd0;
      started_d = 1'b0;
    end else begin
      unique case (mode_q)
        MODE_SLASH: begin
          if (c == 8'h2f) mode_d = MODE_LINE;
          else if (c == 8'h2a) mode_d = MODE_BLOCK;
          else begin
            r[0] = mk(KIND_UNKNOWN, 8'h2f, 1'b1, 1'b1, 1'b1, 1'b0);
            n = 2'd1;
            restart = 1'b1;
          end
        end
        MODE_LINE: if (c == 8'h0a) mode_d = MODE_IDLE;
        MODE_BLOCK: if (c == 8'h2a) mode_d = MODE_BLOCK_STAR;
        MODE_BLOCK_STAR: begin
          if (c == 8'h2f) mode_d = MODE_IDLE;
          else if (c != 8'h2a) mode_d = MODE_BLOCK;
        end
        MODE_IDENT, MODE_NUMBER: begin
          kind = (mode_q == MODE_IDENT) ? KIND_IDENT : KIND_NUMBER;
          more = (mode_q == MODE_IDENT) ? (is_letter(c) || is_digit(c) || c == 8'h5f)
                                        : is_digit(c);
          r[0] = mk(kind, h0_q, 1'b1, !started_q, !more, 1'b0);
          n = 2'd1;
          if (more) begin
            started_d = 1'b1;
            h0_d = c;
          end else begin
            restart = 1'b1;
          end
        end
        MODE_STRING: begin
          if (c == 8'h22) begin
            r[0] = (cnt_q != 2'd0) ? mk(KIND_STRING, h0_q, 1'b1, !started_q, 1'b1, 1'b0)
                                   : mk(KIND_STRING, 8'd0, 1'b0, 1'b1, 1'b1, 1'b0);
            n = 2'd1;
            mode_d = MODE_IDLE;
            h0_d = 8'd0;
            h1_d = 8'd0;
            cnt_d = 2'd0;
            started_d = 1'b0;
          end else if (c == 8'h5c) begin
            mode_d = MODE_STRING_ESC;
          end else begin
            if (cnt_q != 2'd0) begin
              r[0] = mk(KIND_STRING, h0_q, 1'b1, !started_q, 1'b0, 1'b0);
              n = 2'd1;
              started_d = 1'b1;
            end
            h0_d = c;
            cnt_d = 2'd1;
          end
        end
        MODE_STRING_ESC: begin
          if (cnt_q != 2'd0) begin
            r[0] = mk(KIND_STRING, h0_q, 1'b1, !started_q, 1'b0, 1'b0);
            n = 2'd1;
            started_d = 1'b1;
          end
          h0_d = c;
          cnt_d = 2'd1;
          mode_d = MODE_STRING;
        end
        MODE_SYM: begin
          st_done = 1'b1;
          if (cnt_q >= 2'd2) begin
            if (c == 8'h3e) mk_kind = KIND_IFF;
            else st_done = 1'b0;
          end else if (h0_q == 8'h3c && c == 8'h2d) begin
            h1_d = c;
            cnt_d = 2'd2;
            st_done = 1'b0;
            mk_kind = KIND_IDENT;
          end else if (h0_q == 8'h2d && c == 8'h3e) mk_kind = KIND_IMPLIES;
          else if (h0_q == 8'h26 && c == 8'h26) mk_kind = KIND_ANDAND;
          else if (h0_q == 8'h7c && c == 8'h7c) mk_kind = KIND_OROR;
          else if (h0_q == 8'h2e && c == 8'h2e) mk_kind = KIND_DOTDOT;
          else st_done = 1'b0;
          if (st_done) begin
            if (cnt_q >= 2'd2) begin
              r[0] = mk(mk_kind, h0_q, 1'b1, 1'b1, 1'b0, 1'b0);
              r[1] = mk(mk_kind, h1_q, 1'b1, 1'b0, 1'b0, 1'b0);
              r[2] = mk(mk_kind, c, 1'b1, 1'b0, 1'b1, 1'b0);
              n = 2'd3;
            end else begin
              r[0] = mk(mk_kind, h0_q, 1'b1, 1'b1, 1'b0, 1'b0);
              r[1] = mk(mk_kind, c, 1'b1, 1'b0, 1'b1, 1'b0);
              n = 2'd2;
            end
            mode_d = MODE_IDLE;
            h0_d = 8'd0;
            h1_d = 8'd0;
            cnt_d = 2'd0;
            started_d = 1'b0;
          end else if (!(cnt_q < 2'd2 && h0_q == 8'h3c && c == 8'h2d)) begin
            r[0] = mk(single_kind(h0_q), h0_q, 1'b1, 1'b1, 1'b1, 1'b0);
            r[1] = mk(single_kind(h1_q), h1_q, 1'b1, 1'b1, 1'b1, 1'b0);
            n = (cnt_q >= 2'd2) ? 2'd2 : 2'd1;
            restart = 1'b1;
          end
        end
        default: restart = 1'b1;
      endcase
      if (restart) begin
        sm = MODE_IDLE;
        s0 = 8'd0;
        sc = 2'd0;
        if (is_space(c)) begin
          sm = MODE_IDLE;
        end else if (c == 8'h2f) begin
          sm = MODE_SLASH;
        end else if (is_letter(c) || c == 8'h5f) begin
          sm = MODE_IDENT; s0 = c; sc = 2'd1;
        end else if (is_digit(c)) begin
          sm = MODE_NUMBER; s0 = c; sc = 2'd1;
        end else if (c == 8'h22) begin
          sm = MODE_STRING;
        end else if (c == 8'h3c || c == 8'h2d || c == 8'h26 || c == 8'h7c || c == 8'h2e) begin
          sm = MODE_SYM; s0 = c; sc = 2'd1;
        end else begin
          r[n] = mk(single_kind(c), c, 1'b1, 1'b1, 1'b1, 1'b0);
          n = n + 2'd1;
        end
        mode_d = sm;
        h0_d = s0;
        h1_d = 8'd0;
        cnt_d = sc;
        started_d = 1'b0;
      end
    end
    for (int i = 0; i < MaxRes; i++) begin
      if (n == 2'(i + 1)) r[i].last_of_run = 1'b1;
    end
    b.count = n;
    b.res0 = r[0];
    b.res1 = r[1];
    b.res2 = r[2];
  end

  assign batch_o = b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      h0_q <= 8'd0;
      h1_q <= 8'd0;
      cnt_q <= 2'd0;
      started_q <= 1'b0;
    end else if (take_i) begin
      mode_q <= mode_d;
      h0_q <= h0_d;
      h1_q <= h1_d;
      cnt_q <= cnt_d;
      started_q <= started_d;
    end
  end

endmodule

// File: hdl/sll_back.sv
// Back end: queue of result batches, unrolled into single result items.
module sll_back import sll_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  batch_t    batch_i,
  output logic      full_o,
  output logic      empty_o,
  input  logic      pop_i,
  output out_item_t item_o
);

  localparam int unsigned PtrW = $clog2(QueueDepth);

  batch_t        mem_q [QueueDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [PtrW:0]   fill_q;
  logic [1:0]      sub_q;
  batch_t          head;
  logic            wr, rd, head_ok;

  assign head = mem_q[rd_q];
  assign head_ok = fill_q != '0;
  assign full_o = fill_q == (PtrW+1)'(QueueDepth);
  assign wr = push_i && !full_o && batch_i.count != 2'd0;

  always_comb begin
    unique case (sub_q)
      2'd0: item_o = head.res0;
      2'd1: item_o = head.res1;
      default: item_o = head.res2;
    endcase
  end

  assign empty_o = !head_ok;
  assign rd = pop_i && head_ok && (sub_q + 2'd1 == head.count);

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wr_q] <= batch_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      fill_q <= '0;
      sub_q <= 2'd0;
    end else begin
      if (wr) wr_q <= wr_q + 1'b1;
      if (rd) rd_q <= rd_q + 1'b1;
      fill_q <= fill_q + (PtrW+1)'(wr) - (PtrW+1)'(rd);
      if (rd) sub_q <= 2'd0;
      else if (pop_i && head_ok) sub_q <= sub_q + 2'd1;
    end
  end

endmodule

// File: hdl/spec_language_lexer_unit.sv
// Top level of the lexer unit: front classifier feeding a batch queue.
// Reset clears lexer state and queue at once; results queue as their item is taken.
// Throughput: one input item per cycle while the four-entry batch queue has room.
// Output: one result item per cycle while pop is high and the queue is not empty;
// an item's up to three results leave on successive pops.
`include "spec_language_lexer_unit_defines.svh"
module spec_language_lexer_unit import sll_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push,
  output logic      full,
  input  in_item_t  in_item_i,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_item_o
);

  batch_t batch;
  logic   take;

  assign take = push && !full;

  sll_front u_front (
    .clk_i, .rst_ni, .take_i(take), .item_i(in_item_i), .batch_o(batch)
  );

  sll_back u_back (
    .clk_i, .rst_ni, .push_i(push), .batch_i(batch), .full_o(full),
    .empty_o(empty), .pop_i(pop), .item_o(out_item_o)
  );

  `SLL_ASSERT(a_err_alone, clk_i, rst_ni, !empty && out_item_o.parse_error |-> out_item_o.last_of_run, "error result not last of run")
  `SLL_ASSERT(a_end_marks, clk_i, rst_ni, !empty && out_item_o.token_kind == KIND_END |-> out_item_o.first_of_token && out_item_o.last_of_token && out_item_o.last_of_run, "end result marks wrong")
  `SLL_ASSERT(a_count_ok, clk_i, rst_ni, batch.count != 2'd3 || batch.res2.last_of_run, "batch count mismatch")

endmodule

// File: sim/spec_language_lexer_unit_tb.sv
// Self-checking testbench for the lexer unit: directed and random text against a predictor.
`timescale 1ns / 100ps
module spec_language_lexer_unit_tb;
  import sll_pkg::*;

  localparam int unsigned CycleLimit = 300000;
  localparam int unsigned HoldCycles = 150;
  localparam string SingleSyms = "{}()[];:,@'!&|";
  localparam logic [7:0] ChSlash = 8'h2f;
  localparam logic [7:0] ChStar = 8'h2a;
  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChBackslash = 8'h5c;
  localparam logic [7:0] ChNewline = 8'h0a;
  localparam logic [7:0] ChUnder = 8'h5f;

  logic      clk_i;
  logic      rst_ni;
  logic      push;
  logic      full;
  in_item_t  in_item_i;
  logic      empty;
  logic      pop;
  out_item_t out_item_o;

  spec_language_lexer_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .push(push), .full(full), .in_item_i(in_item_i),
    .empty(empty), .pop(pop), .out_item_o(out_item_o)
  );

  out_item_t   token_q[$];
  int          run_n;
  mode_e       lx_mode;
  logic [7:0]  lx_held[2];
  int          lx_cnt;
  bit          lx_started;
  int          fails;
  int          items_sent;
  int unsigned cycles;
  bit          hold_on;
  int          pop_gap;
  bit          quiet;
  event        hold_start;

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic bit is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit is_num(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_blank(logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic [4:0] sym_kind(logic [7:0] c);
    for (int i = 0; i < 14; i++)
      if (SingleSyms[i] == c) return KIND_SINGLE0 + 5'(i);
    return KIND_UNKNOWN;
  endfunction

  function automatic void put_token(logic [4:0] kind, logic [7:0] ch, bit has, bit first,
                                    bit last, bit err);
    out_item_t r;
    if (run_n >= 3) return;
    r.token_kind = kind;
    r.char_code_res = has ? ch : 8'd0;
    r.has_char = has;
    r.first_of_token = first;
    r.last_of_token = last;
    r.parse_error = err;
    r.last_of_run = 1'b0;
    token_q.insert(token_q.size(), r);
    run_n++;
  endfunction

  function automatic void lx_idle();
    lx_mode = MODE_IDLE;
    lx_cnt = 0;
    lx_held[0] = 8'd0;
    lx_held[1] = 8'd0;
    lx_started = 1'b0;
  endfunction

  function automatic void put_held(logic [4:0] kind, bit last);
    put_token(kind, lx_held[0], 1'b1, !lx_started, last, 1'b0);
    lx_started = 1'b1;
  endfunction

  function automatic void lx_hold(mode_e m, logic [7:0] c);
    lx_mode = m;
    lx_held[0] = c;
    lx_cnt = 1;
    lx_started = 1'b0;
  endfunction

  function automatic void lx_start(logic [7:0] c);
    if (is_blank(c)) return;
    if (c == ChSlash) lx_mode = MODE_SLASH;
    else if (is_alpha(c) || c == ChUnder) lx_hold(MODE_IDENT, c);
    else if (is_num(c)) lx_hold(MODE_NUMBER, c);
    else if (c == ChQuote) begin
      lx_mode = MODE_STRING;
      lx_cnt = 0;
      lx_started = 1'b0;
    end else if (c == "<" || c == "-" || c == "&" || c == "|" || c == ".") begin
      lx_hold(MODE_SYM, c);
    end else begin
      put_token(sym_kind(c), c, 1'b1, 1'b1, 1'b1, 1'b0);
    end
  endfunction

  function automatic void sym_flush();
    for (int i = 0; i < lx_cnt && i < 2; i++)
      put_token(sym_kind(lx_held[i]), lx_held[i], 1'b1, 1'b1, 1'b1, 1'b0);
    lx_idle();
  endfunction

  function automatic void put_multi(logic [4:0] kind, logic [7:0] c);
    for (int i = 0; i < lx_cnt && i < 2; i++)
      put_token(kind, lx_held[i], 1'b1, i == 0, 1'b0, 1'b0);
    put_token(kind, c, 1'b1, lx_cnt == 0, 1'b1, 1'b0);
    lx_idle();
  endfunction

  function automatic void sym_char(logic [7:0] c);
    logic [7:0] h;
    h = lx_held[0];
    if (lx_cnt >= 2) begin
      if (c == ">") begin put_multi(KIND_IFF, c); return; end
    end else if (h == "<" && c == "-") begin
      lx_held[1] = c;
      lx_cnt = 2;
      return;
    end else if (h == "-" && c == ">") begin put_multi(KIND_IMPLIES, c); return;
    end else if (h == "&" && c == "&") begin put_multi(KIND_ANDAND, c); return;
    end else if (h == "|" && c == "|") begin put_multi(KIND_OROR, c); return;
    end else if (h == "." && c == ".") begin put_multi(KIND_DOTDOT, c); return;
    end
    sym_flush();
    lx_start(c);
  endfunction

  function automatic void lex_char(logic [7:0] c);
    logic [4:0] kind;
    bit more;
    case (lx_mode)
      MODE_SLASH: begin
        if (c == ChSlash) lx_mode = MODE_LINE;
        else if (c == ChStar) lx_mode = MODE_BLOCK;
        else begin
          put_token(KIND_UNKNOWN, ChSlash, 1'b1, 1'b1, 1'b1, 1'b0);
          lx_idle();
          lx_start(c);
        end
      end
      MODE_LINE: if (c == ChNewline) lx_idle();
      MODE_BLOCK: if (c == ChStar) lx_mode = MODE_BLOCK_STAR;
      MODE_BLOCK_STAR: begin
        if (c == ChSlash) lx_idle();
        else if (c != ChStar) lx_mode = MODE_BLOCK;
      end
      MODE_IDENT, MODE_NUMBER: begin
        kind = (lx_mode == MODE_IDENT) ? KIND_IDENT : KIND_NUMBER;
        more = (lx_mode == MODE_IDENT) ? (is_alpha(c) || is_num(c) || c == ChUnder)
                                       : is_num(c);
        if (more) begin
          put_held(kind, 1'b0);
          lx_held[0] = c;
        end else begin
          put_held(kind, 1'b1);
          lx_idle();
          lx_start(c);
        end
      end
      MODE_STRING: begin
        if (c == ChQuote) begin
          if (lx_cnt != 0) put_held(KIND_STRING, 1'b1);
          else put_token(KIND_STRING, 8'd0, 1'b0, 1'b1, 1'b1, 1'b0);
          lx_idle();
        end else if (c == ChBackslash) begin
          lx_mode = MODE_STRING_ESC;
        end else begin
          if (lx_cnt != 0) put_held(KIND_STRING, 1'b0);
          lx_held[0] = c;
          lx_cnt = 1;
        end
      end
      MODE_STRING_ESC: begin
        if (lx_cnt != 0) put_held(KIND_STRING, 1'b0);
        lx_held[0] = c;
        lx_cnt = 1;
        lx_mode = MODE_STRING;
      end
      MODE_SYM: sym_char(c);
      MODE_ERROR: ;
      default: begin
        lx_idle();
        lx_start(c);
      end
    endcase
  endfunction

  function automatic void lex_end();
    case (lx_mode)
      MODE_IDENT: put_held(KIND_IDENT, 1'b1);
      MODE_NUMBER: put_held(KIND_NUMBER, 1'b1);
      MODE_SLASH: put_token(KIND_UNKNOWN, ChSlash, 1'b1, 1'b1, 1'b1, 1'b0);
      MODE_SYM: sym_flush();
      MODE_STRING, MODE_STRING_ESC: begin
        put_token(KIND_STRING, 8'd0, 1'b0, 1'b0, 1'b0, 1'b1);
        lx_idle();
        lx_mode = MODE_ERROR;
        return;
      end
      default: ;
    endcase
    put_token(KIND_END, 8'd0, 1'b0, 1'b1, 1'b1, 1'b0);
    lx_idle();
  endfunction

  function automatic void predict_tokens(in_item_t it);
    if (lx_mode == MODE_ERROR) return;
    run_n = 0;
    if (it.end_of_input) lex_end();
    else lex_char(it.char_code);
    if (run_n > 0) token_q[token_q.size() - 1].last_of_run = 1'b1;
  endfunction

  function automatic int rand_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 75) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  function automatic void check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      fails++;
    end
  endfunction

  initial begin : hold_ctl
    forever begin
      @(hold_start);
      hold_on = 1'b1;
      repeat (HoldCycles) @(negedge clk_i);
      hold_on = 1'b0;
    end
  end

  always @(negedge clk_i) begin : token_rx
    if (!rst_ni) begin
      pop <= 1'b0;
    end else if (hold_on) begin
      pop <= 1'b0;
    end else if (pop_gap > 0) begin
      pop_gap--;
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
      pop_gap = rand_gap();
    end
  end

  always @(posedge clk_i) begin : token_chk
    out_item_t e;
    if (rst_ni && pop && !empty) begin
      if (token_q.size() == 0) begin
        $error("token item with none expected");
        fails++;
      end else begin
        e = token_q.pop_front();
        check_field("token_kind", e.token_kind, out_item_o.token_kind);
        check_field("char_code_res", e.char_code_res, out_item_o.char_code_res);
        check_field("has_char", e.has_char, out_item_o.has_char);
        check_field("first_of_token", e.first_of_token, out_item_o.first_of_token);
        check_field("last_of_token", e.last_of_token, out_item_o.last_of_token);
        check_field("parse_error", e.parse_error, out_item_o.parse_error);
        check_field("last_of_run", e.last_of_run, out_item_o.last_of_run);
      end
    end
  end

  task automatic send_item(in_item_t it);
    int gap;
    gap = rand_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    push <= 1'b1;
    in_item_i <= it;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    predict_tokens(it);
    items_sent++;
  endtask

  task automatic send_char(logic [7:0] c);
    in_item_t it;
    it.char_code = c;
    it.end_of_input = 1'b0;
    send_item(it);
  endtask

  task automatic send_end();
    in_item_t it;
    it.char_code = 8'($urandom_range(0, 255));
    it.end_of_input = 1'b1;
    send_item(it);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  task automatic wait_drain();
    @(negedge clk_i);
    push <= 1'b0;
    while (token_q.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  function automatic logic [7:0] ident_char();
    int r;
    r = $urandom_range(0, 62);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    if (r < 62) return 8'("0" + r - 52);
    return ChUnder;
  endfunction

  task automatic test_words();
    send_text("_Az9 0189");
    send_end();
    send_text("\"\"\"a\\\"\"");
    send_char(8'd0);
    send_char(8'd255);
    send_end();
    wait_drain();
  endtask

  task automatic test_symbols();
    send_text("<-><-x->&&||..&|.-<");
    send_end();
    wait_drain();
  endtask

  task automatic test_comments();
    send_text("/x//c\n/*a**/b/");
    send_end();
    send_text("/*");
    send_end();
    wait_drain();
  endtask

  task automatic test_backpressure();
    @(negedge clk_i);
    ->hold_start;
    quiet = 1'b1;
    send_text("a1 \"xy\" <-> && [ ] 77");
    send_end();
    quiet = 1'b0;
    wait_drain();
  endtask

  task automatic random_token();
    int n;
    logic [7:0] c;
    case ($urandom_range(0, 10))
      0: begin
        send_char($urandom_range(0, 1) ? ChUnder : 8'("a" + $urandom_range(0, 25)));
        n = $urandom_range(0, 5);
        repeat (n) send_char(ident_char());
      end
      1: begin
        n = $urandom_range(1, 4);
        repeat (n) send_char(8'("0" + $urandom_range(0, 9)));
      end
      2: begin
        send_char(ChQuote);
        n = $urandom_range(0, 4);
        repeat (n) begin
          if ($urandom_range(0, 3) == 0) begin
            send_char(ChBackslash);
            send_char(8'($urandom_range(0, 255)));
          end else begin
            do c = 8'($urandom_range(0, 255)); while (c == ChQuote || c == ChBackslash);
            send_char(c);
          end
        end
        send_char(ChQuote);
      end
      3: begin
        case ($urandom_range(0, 4))
          0: send_text("<->");
          1: send_text("->");
          2: send_text("&&");
          3: send_text("||");
          default: send_text("..");
        endcase
      end
      4: send_char(SingleSyms[$urandom_range(0, 13)]);
      5: send_char($urandom_range(0, 5) == 0 ? 8'h20 : 8'($urandom_range(9, 13)));
      6: begin
        send_text("//");
        n = $urandom_range(0, 4);
        repeat (n) begin
          do c = 8'($urandom_range(0, 255)); while (c == ChNewline);
          send_char(c);
        end
        send_char(ChNewline);
      end
      7: begin
        send_text("/*");
        n = $urandom_range(0, 4);
        repeat (n) send_char($urandom_range(0, 2) == 0 ? ChStar : 8'($urandom_range(0, 255)));
        send_text("*/");
      end
      8, 9: send_char(8'($urandom_range(0, 255)));
      default: begin
        if (lx_mode == MODE_STRING_ESC) send_char(ChQuote);
        if (lx_mode == MODE_STRING) send_char(ChQuote);
        send_end();
      end
    endcase
  endtask

  task automatic test_random();
    int start;
    start = items_sent;
    while (items_sent - start < 270) begin
      if ($urandom_range(0, 40) == 0) quiet = !quiet;
      random_token();
      if ($urandom_range(0, 1)) send_char(8'h20);
    end
    quiet = 1'b0;
    if (lx_mode == MODE_STRING_ESC) send_char(ChQuote);
    if (lx_mode == MODE_STRING) send_char(ChQuote);
    send_end();
    wait_drain();
  endtask

  task automatic test_unterminated_string();
    send_text("\"a\\");
    send_end();
    send_text("ab\"");
    send_end();
    wait_drain();
  endtask

  initial begin
    rst_ni = 1'b0;
    push = 1'b0;
    in_item_i = '0;
    items_sent = 0;
    quiet = 1'b0;
    lx_idle();
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    test_words();
    test_symbols();
    test_comments();
    test_backpressure();
    test_random();
    test_unterminated_string();
    if (fails == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
